// ===== src/pbfn_pkg.sv =====
package pbfn_pkg;

    // Address space and bitmap geometry
    localparam int ADDR_BITS     = 32;
    localparam int PAGE_SHIFT    = 12;
    localparam int MAP_WORD_BITS = 32;
    localparam int PAGE_BITS     = ADDR_BITS - PAGE_SHIFT;
    localparam int BIT_BITS      = $clog2(MAP_WORD_BITS);
    localparam int WIDX_BITS     = PAGE_BITS - BIT_BITS;
    localparam int MAP_WORDS     = 1 << WIDX_BITS;

    // Stream payload layout
    localparam int CMD_BITS       = 2;
    localparam int SIZE_BITS      = 32;
    localparam int TAG_BITS       = 2;
    localparam int IN_FIELD_BITS  = CMD_BITS + ADDR_BITS + SIZE_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 1 + 1 + ADDR_BITS + TAG_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD   = 2'd0,
        CMD_TEST  = 2'd1,
        CMD_NEXT  = 2'd2,
        CMD_RANGE = 2'd3
    } t_cmd;

    typedef enum logic [TAG_BITS-1:0] {
        TAG_NONE = 2'd0,
        TAG_ALL  = 2'd1,
        TAG_SOME = 2'd2
    } t_tag;

    // Controller to datapath
    typedef struct packed {
        logic clr_we;
        logic load;
        logic step;
        logic finish;
    } t_ctrl;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic out_free;
    } t_stat;

endpackage

// ===== src/pbfn_datapath.sv =====
module pbfn_datapath
    import pbfn_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctrl                    i_ctrl,
    output t_stat                    o_stat,
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_tdata
);

    localparam logic [MAP_WORD_BITS-1:0] ONES = '1;

    // Bitmap storage and its registered read port
    logic [MAP_WORD_BITS-1:0] r_mem [MAP_WORDS];
    logic [MAP_WORD_BITS-1:0] r_rdata;
    logic [WIDX_BITS-1:0]     r_clr;

    // Command context
    t_cmd                 r_cmd;
    logic [WIDX_BITS-1:0] r_word, r_sw, r_ew;
    logic [BIT_BITS-1:0]  r_lo, r_hi;
    logic                 r_empty, r_some, r_all;

    // Output register
    logic                 r_out_valid;
    logic                 r_marked, r_found;
    logic [ADDR_BITS-1:0] r_next_addr;
    t_tag                 r_tag;

    // Input field decode
    t_cmd                 in_cmd;
    logic [ADDR_BITS-1:0] in_addr;
    logic [SIZE_BITS-1:0] in_size;
    logic [PAGE_BITS-1:0] in_page, nxt_page, end_page, start_sel, end_sel;
    logic [ADDR_BITS:0]   sum_full, end_full;
    logic [ADDR_BITS-1:0] end_addr;

    assign in_cmd  = t_cmd'(i_s_tdata[CMD_BITS-1:0]);
    assign in_addr = i_s_tdata[CMD_BITS +: ADDR_BITS];
    assign in_size = i_s_tdata[CMD_BITS + ADDR_BITS +: SIZE_BITS];
    assign in_page = in_addr[ADDR_BITS-1:PAGE_SHIFT];
    assign nxt_page = in_page + 1'b1;

    // Range end, saturated at the top of the address space
    assign sum_full = {1'b0, in_addr} + {{(ADDR_BITS + 1 - SIZE_BITS){1'b0}}, in_size};
    assign end_full = sum_full - 1'b1;
    assign end_addr = end_full[ADDR_BITS] ? '1 : end_full[ADDR_BITS-1:0];
    assign end_page = end_addr[ADDR_BITS-1:PAGE_SHIFT];

    always_comb begin
        unique case (in_cmd)
            CMD_NEXT: begin
                start_sel = nxt_page;
                end_sel   = '1;
            end
            CMD_RANGE: begin
                start_sel = in_page;
                end_sel   = end_page;
            end
            default: begin
                start_sel = in_page;
                end_sel   = in_page;
            end
        endcase
    end

    // Per-word evaluation
    logic [BIT_BITS-1:0]      lo_bit, hi_bit, low_idx;
    logic [MAP_WORD_BITS-1:0] mask, hits, bit_sel;
    logic                     last_word, some_n, all_n, scan_done;

    assign lo_bit    = (r_word == r_sw) ? r_lo : '0;
    assign hi_bit    = (r_word == r_ew) ? r_hi : '1;
    assign mask      = (ONES << lo_bit) & (ONES >> (~hi_bit));
    assign hits      = r_rdata & mask;
    assign last_word = (r_word == r_ew);
    assign some_n    = r_some | (|hits);
    assign all_n     = r_all & (hits == mask);
    assign bit_sel   = {{(MAP_WORD_BITS-1){1'b0}}, 1'b1} << r_lo;

    // Lowest set bit of the hit word
    always_comb begin
        low_idx = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (hits[i]) begin
                low_idx = BIT_BITS'(i);
            end
        end
    end

    always_comb begin
        unique case (r_cmd)
            CMD_NEXT:  scan_done = (|hits) || last_word;
            CMD_RANGE: scan_done = r_empty || (some_n && !all_n) || last_word;
            default:   scan_done = 1'b1;
        endcase
    end

    // Clear sweep, add write and word read
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr_we) begin
            r_mem[r_clr] <= '0;
        end else if (i_ctrl.finish && r_cmd == CMD_ADD) begin
            r_mem[r_word] <= r_rdata | bit_sel;
        end
        r_rdata <= r_mem[r_word];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_ctrl.clr_we) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // Load command context, advance the scan
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd   <= in_cmd;
            r_word  <= start_sel[PAGE_BITS-1:BIT_BITS];
            r_sw    <= start_sel[PAGE_BITS-1:BIT_BITS];
            r_lo    <= start_sel[BIT_BITS-1:0];
            r_ew    <= end_sel[PAGE_BITS-1:BIT_BITS];
            r_hi    <= end_sel[BIT_BITS-1:0];
            r_empty <= (in_size == '0);
            r_some  <= 1'b0;
            r_all   <= 1'b1;
        end else if (i_ctrl.step) begin
            r_word <= r_word + 1'b1;
            r_some <= some_n;
            r_all  <= all_n;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.finish) begin
            r_marked    <= (r_cmd == CMD_TEST) && (|(r_rdata & bit_sel));
            r_found     <= (r_cmd == CMD_NEXT) && (|hits);
            r_next_addr <= ((r_cmd == CMD_NEXT) && (|hits))
                         ? {r_word, low_idx, {PAGE_SHIFT{1'b0}}} : '0;
            if (r_cmd == CMD_RANGE && !r_empty && some_n) begin
                r_tag <= all_n ? TAG_ALL : TAG_SOME;
            end else begin
                r_tag <= TAG_NONE;
            end
        end
    end

    assign o_stat.clr_last  = &r_clr;
    assign o_stat.scan_done = scan_done;
    assign o_stat.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_BITS - OUT_FIELD_BITS){1'b0}},
                         r_tag, r_next_addr, r_found, r_marked};

endmodule

// ===== src/pbfn_ctrl.sv =====
module pbfn_ctrl
    import pbfn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EVAL  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence: sweep the bitmap, then read and evaluate one word at a time
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_s_tvalid) n_state = S_READ;
            S_READ:  n_state = S_EVAL;
            S_EVAL: begin
                if (!i_stat.scan_done) begin
                    n_state = S_READ;
                end else if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign o_s_tready    = (r_state == S_IDLE);
    assign o_ctrl.clr_we = (r_state == S_CLEAR);
    assign o_ctrl.load   = (r_state == S_IDLE) && i_s_tvalid;
    assign o_ctrl.step   = (r_state == S_EVAL) && !i_stat.scan_done;
    assign o_ctrl.finish = (r_state == S_EVAL) && i_stat.scan_done && i_stat.out_free;

endmodule

// ===== src/page_bitmap_find_next.sv =====
// Page presence bitmap with one bit per 4 KiB page of a 32-bit address space,
// held in a 32768 x 32 RAM with one write and one read port. After reset
// the block sweeps the RAM to zero, one word per cycle, and accepts no
// transfer until the sweep is done. Each command then reads and evaluates
// one RAM word at a time (read, evaluate): add and test use a single word;
// next and range tag scan N bitmap words (up to 32768 for a next search
// across the whole space, and a range stops early as soon as it sees both
// marked and unmarked pages). One command is in flight at a time; a
// finished result sits in an output register, so the next command can be
// accepted while it waits to be taken.
module page_bitmap_find_next
    import pbfn_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // command[1:0], address[33:2], range_size[65:34], zero fill
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // page_marked[0], found[1], next_page_address[33:2], range_tag[35:34], zero fill
    output logic [OUT_DATA_BITS-1:0] o_m_tdata
);

    t_ctrl ctrl;
    t_stat stat;

    pbfn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    pbfn_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .o_stat     (stat),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== src/pbfn_checker.sv =====
module pbfn_checker
    import pbfn_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_s_tvalid,
    input logic                     o_s_tready,
    input logic [IN_DATA_BITS-1:0]  i_s_tdata,
    input logic                     o_m_tvalid,
    input logic                     i_m_tready,
    input logic [OUT_DATA_BITS-1:0] o_m_tdata
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // One command at a time: no ready right after a transfer
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input ready right after a transfer");

    // Result needs at least a read and an evaluate cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !$rose(o_m_tvalid))
        else $error("result appeared too early");

    // Not found reports address zero
    a_nofind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[1] |-> o_m_tdata[33:2] == '0)
        else $error("next address without found");

    // Range tag code stays in range
    a_tag_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[35:34] != 2'd3)
        else $error("bad range tag");

endmodule

bind page_bitmap_find_next pbfn_checker u_pbfn_checker (.*);
